// File: hdl/sorted_insert_priority_queue_top_defines.svh
// Assertion macros for the sorted insert priority queue.
// Included by the top level; no other dependencies.
`ifndef SORTED_INSERT_PRIORITY_QUEUE_TOP_DEFINES_SVH
`define SORTED_INSERT_PRIORITY_QUEUE_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Checked on every clock edge outside reset.
`define SPQ_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("spq assertion failed");
// Checked on every clock edge, reset included.
`define SPQ_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) (prop)) \
        else $error("spq assertion failed");
`else
`define SPQ_ASSERT(lbl, prop)
`define SPQ_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

// File: hdl/spq_pkg.sv
// Package for the sorted insert priority queue: sizes, command and status
// codes, and the packed item types of the command and result ports.
// No dependencies.
`timescale 1ns / 1ps

package spq_pkg;

    localparam int DEPTH          = 16;
    localparam int NAME_BITS      = 16;
    localparam int IDX_W          = $clog2(DEPTH);
    localparam int CNT_W          = $clog2(DEPTH + 1);

    localparam int CMD_W          = 2;
    localparam int TAG_W          = 16;
    localparam int PRIO_W         = 8;
    localparam int STATUS_W       = 2;
    localparam int ENTRY_COUNT_W  = 5;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SHOW   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
    localparam logic [STATUS_W-1:0] ST_ENTRY = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [TAG_W-1:0]  name_tag;
        logic [PRIO_W-1:0] priority_req;
    } t_spq_cmd;

    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic [TAG_W-1:0]         entry_name;
        logic [PRIO_W-1:0]        entry_priority;
        logic [ENTRY_COUNT_W-1:0] entry_count;
        logic                     last;
    } t_spq_res;

endpackage

// File: hdl/sorted_insert_priority_queue_top.sv
// Sorted insert priority queue top level: sequencer, entry memory and
// result register. Depends on spq_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "sorted_insert_priority_queue_top_defines.svh"

// A command is taken when start is high and busy is low; busy stays high
// until its last result has been shown. Every result appears for one cycle
// with o_valid high and must be taken then, since the receiver cannot stall
// the block. An insert walks the sorted memory from the tail toward the head
// one entry per cycle through a single compare and a single read and write
// port. It ends in S_INS_CMP on its first compare when the new entry lands
// at the tail, and passes through S_INS_PUT when it lands at the head. A
// refused or first insert, a clear and an empty show give their result
// straight from S_IDLE. A show of N entries emits one result per cycle in
// S_SHOW. The memory needs no clearing pass.
module sorted_insert_priority_queue_top
    import spq_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    input  t_spq_cmd i_cmd,
    output logic     busy,
    output logic     o_valid,
    output t_spq_res o_result
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_INS_CMP,
        S_INS_PUT,
        S_SHOW
    } t_state;

    t_state                r_state, n_state;
    logic [IDX_W-1:0]      r_idx, n_idx;
    logic [CNT_W-1:0]      r_count, n_count;
    logic [NAME_BITS-1:0]  r_tag, n_tag;
    logic [PRIO_W-1:0]     r_prio, n_prio;
    logic                  r_valid, n_valid;
    t_spq_res              r_out, n_out;

    // Entry memory: one write and one registered read per cycle.
    logic [NAME_BITS-1:0]  r_name_mem [DEPTH];
    logic [PRIO_W-1:0]     r_prio_mem [DEPTH];
    logic [NAME_BITS-1:0]  r_rd_name;
    logic [PRIO_W-1:0]     r_rd_prio;

    logic                  wr_en;
    logic [IDX_W-1:0]      wr_addr;
    logic [NAME_BITS-1:0]  wr_name;
    logic [PRIO_W-1:0]     wr_prio;
    logic [IDX_W-1:0]      rd_addr;

    function automatic t_spq_res f_res(input logic [STATUS_W-1:0] st,
                                       input logic [CNT_W-1:0] cnt);
        t_spq_res res;
        res                = '0;
        res.status         = st;
        res.entry_count    = ENTRY_COUNT_W'(cnt);
        res.last           = 1'b1;
        return res;
    endfunction

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_count = r_count;
        n_tag   = r_tag;
        n_prio  = r_prio;
        n_valid = 1'b0;
        n_out   = r_out;
        wr_en   = 1'b0;
        wr_addr = r_idx;
        wr_name = r_tag;
        wr_prio = r_prio;
        rd_addr = r_idx;

        case (r_state)
            S_IDLE: begin
                // Prefetch the tail for an insert, the head for a show.
                if (i_cmd.command == CMD_SHOW) begin
                    rd_addr = '0;
                end else begin
                    rd_addr = IDX_W'(r_count - CNT_W'(1));
                end
                if (start) begin
                    n_tag  = NAME_BITS'(i_cmd.name_tag);
                    n_prio = i_cmd.priority_req;
                    case (i_cmd.command)
                        CMD_INSERT: begin
                            if (r_count >= CNT_W'(DEPTH)) begin
                                n_valid = 1'b1;
                                n_out   = f_res(ST_FULL, r_count);
                            end else if (r_count == '0) begin
                                wr_en   = 1'b1;
                                wr_addr = '0;
                                wr_name = NAME_BITS'(i_cmd.name_tag);
                                wr_prio = i_cmd.priority_req;
                                n_count = CNT_W'(1);
                                n_valid = 1'b1;
                                n_out   = f_res(ST_DONE, CNT_W'(1));
                            end else begin
                                n_idx   = IDX_W'(r_count);
                                n_state = S_INS_CMP;
                            end
                        end
                        CMD_SHOW: begin
                            if (r_count == '0) begin
                                n_valid = 1'b1;
                                n_out   = f_res(ST_EMPTY, r_count);
                            end else begin
                                n_idx   = '0;
                                n_state = S_SHOW;
                            end
                        end
                        CMD_CLEAR: begin
                            n_count = '0;
                            n_valid = 1'b1;
                            n_out   = f_res(ST_DONE, '0);
                        end
                        default: begin
                            n_valid = 1'b1;
                            n_out   = f_res(ST_DONE, r_count);
                        end
                    endcase
                end
            end
            S_INS_CMP: begin
                // r_idx is the free slot; the entry just above it is in the read register.
                wr_en = 1'b1;
                if (r_rd_prio >= r_prio) begin
                    n_count = r_count + CNT_W'(1);
                    n_valid = 1'b1;
                    n_out   = f_res(ST_DONE, r_count + CNT_W'(1));
                    n_state = S_IDLE;
                end else begin
                    wr_name = r_rd_name;
                    wr_prio = r_rd_prio;
                    n_idx   = r_idx - IDX_W'(1);
                    if (r_idx == IDX_W'(1)) begin
                        n_state = S_INS_PUT;
                    end else begin
                        rd_addr = r_idx - IDX_W'(2);
                    end
                end
            end
            S_INS_PUT: begin
                wr_en   = 1'b1;
                n_count = r_count + CNT_W'(1);
                n_valid = 1'b1;
                n_out   = f_res(ST_DONE, r_count + CNT_W'(1));
                n_state = S_IDLE;
            end
            S_SHOW: begin
                rd_addr              = r_idx + IDX_W'(1);
                n_idx                = r_idx + IDX_W'(1);
                n_valid              = 1'b1;
                n_out                = f_res(ST_ENTRY, r_count);
                n_out.entry_name     = TAG_W'(r_rd_name);
                n_out.entry_priority = r_rd_prio;
                n_out.last           = (CNT_W'(r_idx) + CNT_W'(1)) == r_count;
                if (n_out.last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_name_mem[wr_addr] <= wr_name;
            r_prio_mem[wr_addr] <= wr_prio;
        end
        r_rd_name <= r_name_mem[rd_addr];
        r_rd_prio <= r_prio_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_count <= n_count;
            r_valid <= n_valid;
            r_tag   <= n_tag;
            r_prio  <= n_prio;
            r_out   <= n_out;
        end
    end

    assign busy     = (r_state != S_IDLE);
    assign o_valid  = r_valid;
    assign o_result = r_out;

    `SPQ_ASSERT(a_count_bounded, r_count <= CNT_W'(DEPTH))
    `SPQ_ASSERT(a_last_frees_block, o_valid |-> (o_result.last == !busy))
    `SPQ_ASSERT(a_count_moves_with_result, !$stable(r_count) |-> o_valid)
    `SPQ_ASSERT(a_full_insert_keeps_count,
        (start && !busy && i_cmd.command == CMD_INSERT && r_count == CNT_W'(DEPTH))
        |=> (r_count == CNT_W'(DEPTH) && o_valid && o_result.status == ST_FULL))

endmodule
